@@ src/jsu_pkg.sv @@
// Shared widths, character codes and UTF-8 constants for the JSON string unescaper.
`timescale 1ns / 1ps

package jsu_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CODE_W  = 16;
  localparam int unsigned HELD_N  = 3;
  localparam int unsigned RES_N   = 3;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [CODE_W-1:0] code_t;
  typedef logic [1:0]        cnt_t;

  // Characters that steer the escape decoder.
  localparam byte_t CH_BSLASH = 8'h5c;
  localparam byte_t CH_QUOTE  = 8'h22;
  localparam byte_t CH_SLASH  = 8'h2f;
  localparam byte_t CH_B      = 8'h62;
  localparam byte_t CH_F      = 8'h66;
  localparam byte_t CH_N      = 8'h6e;
  localparam byte_t CH_R      = 8'h72;
  localparam byte_t CH_T      = 8'h74;
  localparam byte_t CH_U      = 8'h75;

  // Control characters that the letter escapes stand for.
  localparam byte_t CTL_BS = 8'h08;
  localparam byte_t CTL_FF = 8'h0c;
  localparam byte_t CTL_LF = 8'h0a;
  localparam byte_t CTL_CR = 8'h0d;
  localparam byte_t CTL_HT = 8'h09;

  // UTF-8 lead and continuation markers.
  localparam byte_t UTF_LEAD2 = 8'hc0;
  localparam byte_t UTF_LEAD3 = 8'he0;
  localparam byte_t UTF_CONT  = 8'h80;
  localparam code_t UTF_MAX1  = 16'h007f;
  localparam code_t UTF_MAX2  = 16'h07ff;

endpackage

@@ src/jsu_if.sv @@
// Valid/ready channel interfaces for raw input bytes and unescaped result bytes.
`timescale 1ns / 1ps

interface jsu_in_if;
  logic                valid;
  logic                ready;
  logic [jsu_pkg::BYTE_W-1:0] in_byte;
  logic                end_of_text;

  modport source (output valid, output in_byte, output end_of_text, input ready);
  modport sink   (input valid, input in_byte, input end_of_text, output ready);
endinterface

interface jsu_out_if;
  logic                valid;
  logic                ready;
  logic [jsu_pkg::BYTE_W-1:0] out_byte;
  logic                has_byte;
  logic                run_last;
  logic                text_last;

  modport source (output valid, output out_byte, output has_byte, output run_last,
                  output text_last, input ready);
  modport sink   (input valid, input out_byte, input has_byte, input run_last,
                  input text_last, output ready);
endinterface

@@ src/json_string_unescape_decoder.sv @@
// Top level of the JSON string unescaper: escape decoder and result buffer.
`timescale 1ns / 1ps

// Channel   Direction  Carries
// in_s      sink       in_byte, end_of_text: one raw byte of the string body
// out_m     source     out_byte, has_byte, run_last, text_last: one result byte
//
// Each accepted input item is decoded in the cycle it arrives and its zero to
// three result items are written into a three-entry result buffer. The buffer
// sends one result per cycle while the output is ready. A new item is taken
// when the buffer is empty or while the last buffered result leaves. Reset
// (rst_n low, synchronous) clears the escape state and empties the buffer; a
// stalled output simply holds the buffer.

module json_string_unescape_decoder (
  input  logic      clk,
  input  logic      rst_n,
  jsu_in_if.sink    in_s,
  jsu_out_if.source out_m
);

  // Escape decoder state.
  logic                    esc_r,    esc_nxt;
  logic                    uni_r,    uni_nxt;
  jsu_pkg::cnt_t           hcnt_r,   hcnt_nxt;
  jsu_pkg::code_t          code_r,   code_nxt;
  logic                    stop_r,   stop_nxt;
  jsu_pkg::byte_t          held_r [jsu_pkg::HELD_N];

  // Result buffer: entry 0 is the one on the output.
  jsu_pkg::byte_t          rbyte_r [jsu_pkg::RES_N];
  logic                    rhas_r  [jsu_pkg::RES_N];
  jsu_pkg::cnt_t           rcnt_r;
  logic                    rlast_r;

  // Decoder results for the item on the input.
  jsu_pkg::byte_t          res_byte [jsu_pkg::RES_N];
  logic                    res_has;
  jsu_pkg::cnt_t           res_cnt;
  logic                    held_we;

  logic                    accept;
  logic                    pop;
  logic                    is_hex;
  logic [3:0]              hex_val;
  logic                    stop_t;
  jsu_pkg::code_t          code_t_v;
  jsu_pkg::byte_t          b;

  // Hex digit decode of the current byte.
  always_comb begin
    b       = in_s.in_byte;
    is_hex  = 1'b0;
    hex_val = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      is_hex  = 1'b1;
      hex_val = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      is_hex  = 1'b1;
      hex_val = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      is_hex  = 1'b1;
      hex_val = 4'(b - 8'h37);
    end
    // Once a non-hex character is seen, the value stops growing for this escape.
    stop_t   = stop_r | ~is_hex;
    code_t_v = stop_t ? code_r : {code_r[jsu_pkg::CODE_W-5:0], hex_val};
  end

  // Escape decoder: next state and the result bytes of the current item.
  always_comb begin
    esc_nxt  = esc_r;
    uni_nxt  = uni_r;
    hcnt_nxt = hcnt_r;
    code_nxt = code_r;
    stop_nxt = stop_r;
    held_we  = 1'b0;
    res_has  = 1'b1;
    res_cnt  = 2'd0;
    for (int i = 0; i < jsu_pkg::RES_N; i++) begin
      res_byte[i] = '0;
    end

    if (uni_r) begin
      if (hcnt_r != 2'd3) begin
        // Hold the character in case the string ends before the escape does.
        held_we  = 1'b1;
        stop_nxt = stop_t;
        code_nxt = code_t_v;
        hcnt_nxt = hcnt_r + 2'd1;
        if (in_s.end_of_text) begin
          case (hcnt_r)
            2'd0: begin
              res_byte[0] = b;
            end
            2'd1: begin
              res_byte[0] = held_r[0];
              res_byte[1] = b;
            end
            default: begin
              res_byte[0] = held_r[0];
              res_byte[1] = held_r[1];
              res_byte[2] = b;
            end
          endcase
          res_cnt = hcnt_r + 2'd1;
        end
      end else begin
        // Fourth character: send the gathered value as UTF-8.
        if (code_t_v <= jsu_pkg::UTF_MAX1) begin
          res_byte[0] = {1'b0, code_t_v[6:0]};
          res_cnt     = 2'd1;
        end else if (code_t_v <= jsu_pkg::UTF_MAX2) begin
          res_byte[0] = jsu_pkg::UTF_LEAD2 | {3'b000, code_t_v[10:6]};
          res_byte[1] = jsu_pkg::UTF_CONT  | {2'b00, code_t_v[5:0]};
          res_cnt     = 2'd2;
        end else begin
          res_byte[0] = jsu_pkg::UTF_LEAD3 | {4'b0000, code_t_v[15:12]};
          res_byte[1] = jsu_pkg::UTF_CONT  | {2'b00, code_t_v[11:6]};
          res_byte[2] = jsu_pkg::UTF_CONT  | {2'b00, code_t_v[5:0]};
          res_cnt     = 2'd3;
        end
        uni_nxt  = 1'b0;
        hcnt_nxt = 2'd0;
        code_nxt = '0;
        stop_nxt = 1'b0;
      end
    end else if (esc_r) begin
      esc_nxt = 1'b0;
      res_cnt = 2'd1;
      unique case (b)
        jsu_pkg::CH_U: begin
          uni_nxt  = 1'b1;
          hcnt_nxt = 2'd0;
          code_nxt = '0;
          stop_nxt = 1'b0;
          res_cnt  = 2'd0;
        end
        jsu_pkg::CH_QUOTE, jsu_pkg::CH_SLASH, jsu_pkg::CH_BSLASH: res_byte[0] = b;
        jsu_pkg::CH_B: res_byte[0] = jsu_pkg::CTL_BS;
        jsu_pkg::CH_F: res_byte[0] = jsu_pkg::CTL_FF;
        jsu_pkg::CH_N: res_byte[0] = jsu_pkg::CTL_LF;
        jsu_pkg::CH_R: res_byte[0] = jsu_pkg::CTL_CR;
        jsu_pkg::CH_T: res_byte[0] = jsu_pkg::CTL_HT;
        default:       res_cnt     = 2'd0;
      endcase
    end else if (b == jsu_pkg::CH_BSLASH) begin
      esc_nxt = 1'b1;
    end else begin
      res_byte[0] = b;
      res_cnt     = 2'd1;
    end

    if (in_s.end_of_text) begin
      // The string is over: back to the reset state.
      esc_nxt  = 1'b0;
      uni_nxt  = 1'b0;
      hcnt_nxt = 2'd0;
      code_nxt = '0;
      stop_nxt = 1'b0;
      // A byte that yields nothing still closes the string with a bare marker.
      if (res_cnt == 2'd0) begin
        res_cnt     = 2'd1;
        res_has     = 1'b0;
        res_byte[0] = '0;
      end
    end
  end

  // The buffer may be reloaded once its last entry is leaving.
  assign pop        = out_m.valid & out_m.ready;
  assign in_s.ready = (rcnt_r == 2'd0) | ((rcnt_r == 2'd1) & out_m.ready);
  assign accept     = in_s.valid & in_s.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      esc_r  <= 1'b0;
      uni_r  <= 1'b0;
      hcnt_r <= 2'd0;
      code_r <= '0;
      stop_r <= 1'b0;
      rcnt_r <= 2'd0;
    end else if (accept) begin
      esc_r  <= esc_nxt;
      uni_r  <= uni_nxt;
      hcnt_r <= hcnt_nxt;
      code_r <= code_nxt;
      stop_r <= stop_nxt;
      rcnt_r <= res_cnt;
    end else if (pop) begin
      rcnt_r <= rcnt_r - 2'd1;
    end
  end

  // Held characters and buffer payload need no reset.
  always_ff @(posedge clk) begin
    if (accept && held_we) begin
      held_r[hcnt_r] <= b;
    end
    if (accept) begin
      rlast_r <= in_s.end_of_text;
      for (int i = 0; i < jsu_pkg::RES_N; i++) begin
        rbyte_r[i] <= res_byte[i];
        rhas_r[i]  <= res_has;
      end
    end else if (pop) begin
      for (int i = 0; i < jsu_pkg::RES_N - 1; i++) begin
        rbyte_r[i] <= rbyte_r[i+1];
        rhas_r[i]  <= rhas_r[i+1];
      end
    end
  end

  assign out_m.valid     = (rcnt_r != 2'd0);
  assign out_m.out_byte  = rbyte_r[0];
  assign out_m.has_byte  = rhas_r[0];
  assign out_m.run_last  = (rcnt_r == 2'd1);
  assign out_m.text_last = (rcnt_r == 2'd1) & rlast_r;

endmodule
